// File: rtl/adll_pkg.sv
`default_nettype none
// shared constants, types and helper functions of the array doubly linked list
package adll_pkg;

	// pool size must be a power of two: outside indices wrap by dropping high bits
	localparam int POOL_SLOTS = 1024;
	localparam int DATA_BITS  = 32;

	localparam int SLOT_W = $clog2(POOL_SLOTS);
	localparam int NF_W   = $clog2(POOL_SLOTS + 1);
	localparam int IDX_W  = 11;
	localparam int VAL_W  = 32;
	localparam int OP_W   = 3;
	localparam int SUM_W  = ((SLOT_W > IDX_W) ? SLOT_W : IDX_W) + 1;
	localparam int CNT_W  = ((NF_W > IDX_W) ? NF_W : IDX_W) + 1;
	localparam int EXT_W  = VAL_W + DATA_BITS;

	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [NF_W-1:0]      nf_t;
	typedef logic [DATA_BITS-1:0] data_t;

	typedef enum logic [OP_W-1:0] {
		OP_START      = 3'd0,
		OP_LOAD       = 3'd1,
		OP_INS_AFTER  = 3'd2,
		OP_INS_BEFORE = 3'd3,
		OP_REMOVE     = 3'd4
	} adll_op_t;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_INS,
		ST_RD_RM,
		ST_INS_NEW,
		ST_INS_LINK,
		ST_RM_LINK
	} adll_state_t;

	typedef struct packed {
		logic start_op;
		logic load_op;
		logic capture;
		logic after;
		logic read;
		logic ins_new;
		logic ins_link;
		logic rm_link;
		logic refuse_ins;
		logic refuse_rm;
	} adll_cmd_t;

	typedef struct packed {
		logic pool_full;
		logic at_sentinel;
	} adll_status_t;

	// outside index plus one, wrapped into the pool
	function automatic slot_t to_slot(input logic [IDX_W-1:0] f);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'($signed(f)) + SUM_W'(1);
		return sum[SLOT_W-1:0];
	endfunction

	function automatic data_t to_data(input logic [VAL_W-1:0] v);
		logic [EXT_W-1:0] w;
		w = EXT_W'($signed(v));
		return w[DATA_BITS-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] to_result(input data_t d);
		logic [EXT_W-1:0] w;
		w = EXT_W'($signed(d));
		return w[VAL_W-1:0];
	endfunction

	// first free slot after a start: negative count is zero, overflow is full
	function automatic nf_t start_count(input logic [IDX_W-1:0] n);
		logic signed [CNT_W-1:0] c;
		c = CNT_W'($signed(n));
		if (c < 0) begin
			c = '0;
		end
		c = c + CNT_W'(1);
		if (c > $signed(CNT_W'(POOL_SLOTS))) begin
			return NF_W'(POOL_SLOTS);
		end
		return c[NF_W-1:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/adll_ctrl.sv
`default_nettype none
// operation sequencer of the array doubly linked list
module adll_ctrl import adll_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [OP_W-1:0]    op,
	input  adll_status_t       status,
	output logic               busy,
	output adll_cmd_t          cmd
);

	adll_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (op)
						OP_START: begin
							cmd.start_op = 1'b1;
						end
						OP_LOAD: begin
							cmd.load_op = 1'b1;
						end
						OP_INS_AFTER, OP_INS_BEFORE: begin
							if (status.pool_full) begin
								cmd.refuse_ins = 1'b1;
							end else begin
								cmd.capture = 1'b1;
								cmd.after   = (op == OP_INS_AFTER);
								state_d     = ST_RD_INS;
							end
						end
						OP_REMOVE: begin
							if (status.at_sentinel) begin
								cmd.refuse_rm = 1'b1;
							end else begin
								cmd.capture = 1'b1;
								state_d     = ST_RD_RM;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_RD_INS: begin
				cmd.read = 1'b1;
				state_d  = ST_INS_NEW;
			end
			ST_RD_RM: begin
				cmd.read = 1'b1;
				state_d  = ST_RM_LINK;
			end
			ST_INS_NEW: begin
				cmd.ins_new = 1'b1;
				state_d     = ST_INS_LINK;
			end
			ST_INS_LINK: begin
				cmd.ins_link = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_RM_LINK: begin
				cmd.rm_link = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/adll_dp.sv
`default_nettype none
// node pool memories, sentinel links, free pointer and result registers
module adll_dp import adll_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  adll_cmd_t               cmd,
	input  logic signed [IDX_W-1:0] node,
	input  logic signed [VAL_W-1:0] value,
	input  logic signed [IDX_W-1:0] link_next,
	input  logic signed [IDX_W-1:0] link_prev,
	output adll_status_t            status,
	output logic                    done,
	output logic                    kind,
	output logic signed [VAL_W-1:0] result_value,
	output logic                    refused
);

	data_t data_mem [POOL_SLOTS];
	slot_t next_mem [POOL_SLOTS];
	slot_t prev_mem [POOL_SLOTS];

	nf_t   nf_q;
	slot_t sent_next_q, sent_prev_q;
	slot_t tgt_q;
	data_t dval_q;
	logic  after_q;

	slot_t rd_next_q, rd_prev_q;
	data_t rd_data_q;
	logic  rd_zero_q;

	logic                done_q, kind_q, refused_q;
	logic [VAL_W-1:0]    res_value_q;

	slot_t tgt_in, newc, nbr_next, nbr_prev;
	logic  same;

	logic  data_we, next_we, prev_we;
	slot_t data_wa, next_wa, prev_wa;
	data_t data_wd;
	slot_t next_wd, prev_wd;

	assign tgt_in   = to_slot(node);
	assign newc     = nf_q[SLOT_W-1:0];
	assign nbr_next = rd_zero_q ? sent_next_q : rd_next_q;
	assign nbr_prev = rd_zero_q ? sent_prev_q : rd_prev_q;
	assign same     = (tgt_q == newc);

	assign status.pool_full   = (nf_q >= NF_W'(POOL_SLOTS));
	assign status.at_sentinel = (tgt_in == '0);

	// write port selection
	always_comb begin
		data_we = 1'b0;
		data_wa = newc;
		data_wd = dval_q;
		next_we = 1'b0;
		next_wa = newc;
		next_wd = newc;
		prev_we = 1'b0;
		prev_wa = newc;
		prev_wd = newc;
		if (cmd.load_op) begin
			data_we = 1'b1;
			data_wa = tgt_in;
			data_wd = to_data(value);
			next_we = 1'b1;
			next_wa = tgt_in;
			next_wd = to_slot(link_next);
			prev_we = 1'b1;
			prev_wa = tgt_in;
			prev_wd = to_slot(link_prev);
		end else if (cmd.ins_new) begin
			data_we = 1'b1;
			next_we = 1'b1;
			next_wd = after_q ? nbr_next : tgt_q;
			prev_we = 1'b1;
			prev_wd = after_q ? tgt_q : nbr_prev;
		end else if (cmd.ins_link) begin
			next_we = 1'b1;
			prev_we = 1'b1;
			if (after_q) begin
				next_wa = tgt_q;
				prev_wa = same ? newc : nbr_next;
			end else begin
				prev_wa = tgt_q;
				next_wa = same ? newc : nbr_prev;
			end
		end else if (cmd.rm_link) begin
			prev_we = 1'b1;
			prev_wa = nbr_next;
			prev_wd = nbr_prev;
			next_we = 1'b1;
			next_wa = nbr_prev;
			next_wd = nbr_next;
		end
	end

	always_ff @(posedge clk) begin
		if (data_we) begin
			data_mem[data_wa] <= data_wd;
		end
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (cmd.read) begin
			rd_data_q <= data_mem[tgt_q];
			rd_next_q <= next_mem[tgt_q];
			rd_prev_q <= prev_mem[tgt_q];
			rd_zero_q <= (tgt_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tgt_q   <= tgt_in;
			dval_q  <= to_data(value);
			after_q <= cmd.after;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nf_q        <= NF_W'(1);
			sent_next_q <= '0;
			sent_prev_q <= '0;
			done_q      <= 1'b0;
		end else begin
			if (cmd.start_op) begin
				nf_q        <= start_count(node);
				sent_next_q <= to_slot(link_next);
				sent_prev_q <= to_slot(link_prev);
			end else begin
				if (cmd.ins_link) begin
					nf_q <= nf_q + NF_W'(1);
				end
				if (next_we && (next_wa == '0)) begin
					sent_next_q <= next_wd;
				end
				if (prev_we && (prev_wa == '0)) begin
					sent_prev_q <= prev_wd;
				end
			end
			done_q <= cmd.ins_link | cmd.rm_link | cmd.refuse_ins | cmd.refuse_rm;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_link) begin
			kind_q      <= KIND_INSERT;
			res_value_q <= VAL_W'(slot_t'(newc - SLOT_W'(1)));
			refused_q   <= 1'b0;
		end else if (cmd.rm_link) begin
			kind_q      <= KIND_REMOVE;
			res_value_q <= to_result(rd_data_q);
			refused_q   <= 1'b0;
		end else if (cmd.refuse_ins) begin
			kind_q      <= KIND_INSERT;
			res_value_q <= '0;
			refused_q   <= 1'b1;
		end else if (cmd.refuse_rm) begin
			kind_q      <= KIND_REMOVE;
			res_value_q <= '0;
			refused_q   <= 1'b1;
		end
	end

	assign done         = done_q;
	assign kind         = kind_q;
	assign result_value = res_value_q;
	assign refused      = refused_q;

endmodule
`default_nettype wire

// File: rtl/array_doubly_linked_list.sv
`default_nettype none
// top level of the array doubly linked list: sequencer plus node pool datapath
//
//  channel   ports                                        transaction
//  command   start, busy, op, node, value,                start high while busy low
//            link_next, link_prev
//  result    done, kind, result_value, refused            done high for one cycle
//
// start and load complete at acceptance and give no result; a refused insert or remove
// answers in the cycle after acceptance without a memory access
// insert steps through accept, link read, new node write and neighbour relink, as
// each link memory has a single write port; result in the cycle after
// remove steps through accept, read and unlink; result in the cycle after
// reset clears the sentinel links and sets the free pointer to one; node
// memories are not cleared
// the receiver cannot stall: done is a one cycle strobe, never held
module array_doubly_linked_list import adll_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [OP_W-1:0]         op,
	input  logic signed [IDX_W-1:0] node,
	input  logic signed [VAL_W-1:0] value,
	input  logic signed [IDX_W-1:0] link_next,
	input  logic signed [IDX_W-1:0] link_prev,
	output logic                    done,
	output logic                    kind,
	output logic signed [VAL_W-1:0] result_value,
	output logic                    refused
);

	// commands from the sequencer, pool status back to it
	adll_cmd_t    cmd;
	adll_status_t status;

	// sequencer: decodes the accepted transaction and steps the memory phases
	adll_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	// datapath: data, next and prev memories, sentinel links, free pointer
	adll_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.node         (node),
		.value        (value),
		.link_next    (link_next),
		.link_prev    (link_prev),
		.status       (status),
		.done         (done),
		.kind         (kind),
		.result_value (result_value),
		.refused      (refused)
	);

endmodule
`default_nettype wire

// File: bench/array_doubly_linked_list_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the array doubly linked list: directed cases, then random list sessions
module array_doubly_linked_list_tb;
	import adll_pkg::*;

	localparam int ITEMS        = 1350;
	localparam int DRAIN_CYCLES = 16;
	localparam int TIMEOUT_NS   = 1_000_000;

	// two copies of the list state: one steers the generator, one predicts at acceptance
	localparam int COPIES = 2;
	localparam int PLAN   = 0;
	localparam int CHECK  = 1;

	// op codes past remove are ignored by the block
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_W'(OP_REMOVE + 1);
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = '1;

	// outside index -1 names the sentinel
	localparam logic [IDX_W-1:0] SENTINEL_IDX = '1;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] target;
		logic [VAL_W-1:0] word;
		logic [IDX_W-1:0] next_idx;
		logic [IDX_W-1:0] prev_idx;
		logic             wait_drain;
	} list_cmd_t;

	typedef struct packed {
		logic             kind;
		logic [VAL_W-1:0] val;
		logic             refused;
	} list_reply_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	always #1 clk = ~clk;

	// command side, all driven to known values from time zero
	logic                    start     = 1'b0;
	logic [OP_W-1:0]         op        = '0;
	logic signed [IDX_W-1:0] node      = '0;
	logic signed [VAL_W-1:0] value     = '0;
	logic signed [IDX_W-1:0] link_next = '0;
	logic signed [IDX_W-1:0] link_prev = '0;

	// result side
	logic                    busy;
	logic                    done;
	logic                    kind;
	logic signed [VAL_W-1:0] result_value;
	logic                    refused;

	array_doubly_linked_list u_dut (
		.clk,
		.arst_n,
		.start,
		.busy,
		.op,
		.node,
		.value,
		.link_next,
		.link_prev,
		.done,
		.kind,
		.result_value,
		.refused
	);

	// predicted node pool, with a written mark per entry so no undefined entry is ever read
	data_t pool_data [COPIES][POOL_SLOTS];
	slot_t pool_next [COPIES][POOL_SLOTS];
	slot_t pool_prev [COPIES][POOL_SLOTS];
	bit    data_set  [COPIES][POOL_SLOTS];
	bit    next_set  [COPIES][POOL_SLOTS];
	bit    prev_set  [COPIES][POOL_SLOTS];
	nf_t   first_free [COPIES];

	list_cmd_t   cmds_pending[$];
	list_reply_t replies_due[$];
	int          live_nodes[$];

	list_cmd_t cur;
	logic      taken      = 1'b0;
	int        planned    = 0;
	int        counted    = 0;
	int        issued     = 0;
	int        accepted   = 0;
	int        mismatches = 0;

	// outside index plus one, wrapped into the pool
	function automatic slot_t wrap_index(input logic [IDX_W-1:0] f);
		int s;
		s = $signed(f) + 1;
		return s[SLOT_W-1:0];
	endfunction

	// advance one copy of the list by one command; returns 1 when a result is due
	function automatic bit step_list(input int m, input list_cmd_t c, output list_reply_t r);
		slot_t s;
		slot_t fresh;
		int    cnt;
		s = wrap_index(c.target);
		r = '0;
		case (c.op)
			OP_START: begin
				// negative count is zero, a count past the pool end leaves it full
				cnt = int'($signed(c.target));
				if (cnt < 0) begin
					cnt = 0;
				end
				first_free[m] = (cnt + 1 > POOL_SLOTS) ? NF_W'(POOL_SLOTS) : NF_W'(cnt + 1);
				pool_next[m][0] = wrap_index(c.next_idx);
				pool_prev[m][0] = wrap_index(c.prev_idx);
				return 1'b0;
			end
			OP_LOAD: begin
				pool_data[m][s] = data_t'(c.word);
				pool_next[m][s] = wrap_index(c.next_idx);
				pool_prev[m][s] = wrap_index(c.prev_idx);
				data_set[m][s]  = 1'b1;
				next_set[m][s]  = 1'b1;
				prev_set[m][s]  = 1'b1;
				return 1'b0;
			end
			OP_INS_AFTER, OP_INS_BEFORE: begin
				r.kind = KIND_INSERT;
				if (first_free[m] >= POOL_SLOTS) begin
					r.refused = 1'b1;
					return 1'b1;
				end
				fresh = slot_t'(first_free[m]);
				pool_data[m][fresh] = data_t'(c.word);
				data_set[m][fresh]  = 1'b1;
				// strict write order: new node, target, neighbour (target may be the new slot)
				if (c.op == OP_INS_AFTER) begin
					pool_next[m][fresh] = pool_next[m][s];
					pool_prev[m][fresh] = s;
					pool_next[m][s]     = fresh;
					next_set[m][s]      = 1'b1;
					pool_prev[m][pool_next[m][fresh]] = fresh;
					prev_set[m][pool_next[m][fresh]]  = 1'b1;
				end else begin
					pool_prev[m][fresh] = pool_prev[m][s];
					pool_next[m][fresh] = s;
					pool_prev[m][s]     = fresh;
					prev_set[m][s]      = 1'b1;
					pool_next[m][pool_prev[m][fresh]] = fresh;
					next_set[m][pool_prev[m][fresh]]  = 1'b1;
				end
				next_set[m][fresh] = 1'b1;
				prev_set[m][fresh] = 1'b1;
				first_free[m] = first_free[m] + 1'b1;
				r.val = VAL_W'(fresh) - 1;
				return 1'b1;
			end
			OP_REMOVE: begin
				r.kind = KIND_REMOVE;
				if (s == 0) begin
					r.refused = 1'b1;
					return 1'b1;
				end
				r.val = VAL_W'($signed(pool_data[m][s]));
				// unlink even if already unlinked
				pool_prev[m][pool_next[m][s]] = pool_prev[m][s];
				prev_set[m][pool_next[m][s]]  = 1'b1;
				pool_next[m][pool_prev[m][s]] = pool_next[m][s];
				next_set[m][pool_prev[m][s]]  = 1'b1;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// true when every entry the command reads has been written before
	function automatic bit reads_known(input list_cmd_t c);
		slot_t s;
		s = wrap_index(c.target);
		case (c.op)
			OP_INS_AFTER:  return first_free[PLAN] >= POOL_SLOTS || next_set[PLAN][s];
			OP_INS_BEFORE: return first_free[PLAN] >= POOL_SLOTS || prev_set[PLAN][s];
			OP_REMOVE:     return s == 0 ||
				(data_set[PLAN][s] && next_set[PLAN][s] && prev_set[PLAN][s]);
			default:       return 1'b1;
		endcase
	endfunction

	function automatic list_cmd_t cmd_of(input logic [OP_W-1:0] op_code,
		input logic [IDX_W-1:0] target, input logic [VAL_W-1:0] word,
		input logic [IDX_W-1:0] next_idx, input logic [IDX_W-1:0] prev_idx);
		list_cmd_t c;
		c.op         = op_code;
		c.target     = target;
		c.word       = word;
		c.next_idx   = next_idx;
		c.prev_idx   = prev_idx;
		c.wait_drain = 1'b0;
		return c;
	endfunction

	// mostly a node on the current list, sometimes the sentinel
	function automatic logic [IDX_W-1:0] pick_live();
		if (live_nodes.size() == 0 || $urandom_range(0, 4) == 0) begin
			return SENTINEL_IDX;
		end
		return IDX_W'(live_nodes[$urandom_range(0, live_nodes.size() - 1)]);
	endfunction

	// queue one command and track which outside indices hold list nodes
	task automatic plan(input list_cmd_t c);
		list_reply_t r;
		bit          has_reply;
		int          idx;
		has_reply = step_list(PLAN, c, r);
		cmds_pending.push_back(c);
		planned++;
		if (c.op <= OP_REMOVE) begin
			counted++;
		end
		idx = int'(wrap_index(c.target)) - 1;
		case (c.op)
			OP_START: live_nodes.delete();
			OP_LOAD: begin
				if (idx >= 0) begin
					live_nodes.push_back(idx);
				end
			end
			OP_INS_AFTER, OP_INS_BEFORE: begin
				if (has_reply && !r.refused) begin
					live_nodes.push_back(int'(r.val));
				end
			end
			OP_REMOVE: begin
				if (has_reply && !r.refused) begin
					for (int i = live_nodes.size() - 1; i >= 0; i--) begin
						if (live_nodes[i] == idx) begin
							live_nodes.delete(i);
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	// stimulus, reset and end of run
	initial begin
		list_cmd_t c;
		int        k;
		int        n_ops;
		int        roll;
		int        session;
		bit        big;

		for (int m = 0; m < COPIES; m++) begin
			first_free[m]   = NF_W'(1);
			pool_next[m][0] = '0;
			pool_prev[m][0] = '0;
			next_set[m][0]  = 1'b1;
			prev_set[m][0]  = 1'b1;
		end

		// directed: sentinel removal, inserts on both sides, extremes of the data word
		plan(cmd_of(OP_REMOVE, SENTINEL_IDX, '0, '0, '0));
		plan(cmd_of(OP_INS_AFTER, SENTINEL_IDX, 32'h7fff_ffff, '0, '0));
		plan(cmd_of(OP_INS_BEFORE, SENTINEL_IDX, 32'h8000_0000, '0, '0));
		plan(cmd_of(OP_INS_AFTER, IDX_W'(0), 32'h0000_0000, '0, '0));
		plan(cmd_of(OP_INS_BEFORE, IDX_W'(1), 32'hffff_ffff, '0, '0));
		// removal of a node twice: the unlink is simply repeated
		plan(cmd_of(OP_REMOVE, IDX_W'(2), '0, '0, '0));
		plan(cmd_of(OP_REMOVE, IDX_W'(2), '0, '0, '0));
		plan(cmd_of(OP_REMOVE, IDX_W'(1), '0, '0, '0));
		// unknown op codes carry extreme fields and must be ignored
		plan(cmd_of(OP_SPARE_FIRST, 11'h3ff, 32'hffff_ffff, 11'h400, 11'h3ff));
		plan(cmd_of(OP_W'(OP_SPARE_FIRST + 1), 11'h400, 32'h8000_0000, 11'h3ff, 11'h400));
		plan(cmd_of(OP_SPARE_LAST, 11'h7ff, 32'h7fff_ffff, 11'h000, 11'h7ff));
		// pre-load the slot about to be allocated, then insert relative to it
		plan(cmd_of(OP_LOAD, IDX_W'(4), 32'h5a5a_a5a5, SENTINEL_IDX, SENTINEL_IDX));
		plan(cmd_of(OP_INS_AFTER, IDX_W'(4), 32'h0123_4567, '0, '0));
		// index 1023 wraps onto the sentinel, -1024 wraps onto slot one
		plan(cmd_of(OP_LOAD, 11'h3ff, 32'h1234_5678, 11'h400, 11'h3ff));
		c = cmd_of(OP_REMOVE, 11'h3ff, '0, '0, '0);
		c.wait_drain = 1'b1;
		plan(c);
		// start count that fills every slot leaves the pool full
		plan(cmd_of(OP_START, 11'h3ff, '0, SENTINEL_IDX, SENTINEL_IDX));
		plan(cmd_of(OP_INS_AFTER, SENTINEL_IDX, 32'hdead_beef, '0, '0));
		plan(cmd_of(OP_INS_BEFORE, 11'h3fe, 32'hdead_beef, '0, '0));
		// last free slot taken, then full
		plan(cmd_of(OP_START, 11'h3fe, '0, SENTINEL_IDX, SENTINEL_IDX));
		plan(cmd_of(OP_INS_BEFORE, SENTINEL_IDX, 32'h0000_0001, '0, '0));
		plan(cmd_of(OP_INS_AFTER, SENTINEL_IDX, 32'h0000_0002, '0, '0));
		// negative start count counts as zero
		plan(cmd_of(OP_START, 11'h400, '0, SENTINEL_IDX, SENTINEL_IDX));
		plan(cmd_of(OP_REMOVE, 11'h3fe, '0, '0, '0));

		// random sessions: start, load a proper list, then edit it with some noise mixed in
		counted = 0;
		session = 0;
		while (counted < ITEMS) begin
			big = ($urandom_range(0, 9) == 0);
			k   = big ? $urandom_range(1015, 1023) : $urandom_range(0, 7);
			if (big || k == 0) begin
				c = cmd_of(OP_START, IDX_W'(k), $urandom, SENTINEL_IDX, SENTINEL_IDX);
			end else begin
				c = cmd_of(OP_START, IDX_W'(k), $urandom, IDX_W'(0), IDX_W'(k - 1));
			end
			c.wait_drain = (session % 8 == 3);
			plan(c);
			if (!big) begin
				for (int i = 0; i < k; i++) begin
					plan(cmd_of(OP_LOAD, IDX_W'(i), $urandom,
						(i == k - 1) ? SENTINEL_IDX : IDX_W'(i + 1),
						(i == 0) ? SENTINEL_IDX : IDX_W'(i - 1)));
				end
			end
			n_ops = $urandom_range(10, 40);
			for (int j = 0; j < n_ops; j++) begin
				roll = $urandom_range(0, 99);
				c = cmd_of(OP_INS_AFTER, pick_live(), $urandom, SENTINEL_IDX, SENTINEL_IDX);
				if (roll < 22) begin
					c.op = OP_INS_AFTER;
				end else if (roll < 44) begin
					c.op = OP_INS_BEFORE;
				end else if (roll < 78) begin
					c.op = OP_REMOVE;
				end else if (roll < 86) begin
					// any index at all, removed or never linked nodes included
					c.op     = OP_W'($urandom_range(OP_INS_AFTER, OP_REMOVE));
					c.target = IDX_W'($urandom);
				end else if (roll < 91) begin
					c = cmd_of(OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
						IDX_W'($urandom), $urandom, IDX_W'($urandom), IDX_W'($urandom));
				end else if (roll < 95) begin
					c.op     = OP_REMOVE;
					c.target = SENTINEL_IDX;
				end else if (roll < 98) begin
					c = cmd_of(OP_LOAD, IDX_W'($urandom), $urandom,
						IDX_W'($urandom), IDX_W'($urandom));
				end else begin
					c = cmd_of(OP_START, IDX_W'($urandom), $urandom,
						IDX_W'($urandom), IDX_W'($urandom));
				end
				// never read an entry that was not written
				if (!reads_known(c)) begin
					c.target = SENTINEL_IDX;
				end
				plan(c);
			end
			session++;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every transaction in, every result out, then a short quiet tail
		while (accepted != planned || replies_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// driver: new transaction at the falling edge once the last one was taken
	always @(negedge clk) begin
		int idle_pct;
		idle_pct = (issued < planned / 3) ? 10 : (issued < 2 * planned / 3) ? 60 : 0;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || taken) begin
			// a flagged transaction waits until nothing is outstanding
			if (cmds_pending.size() != 0 &&
				!(cmds_pending[0].wait_drain && replies_due.size() != 0) &&
				$urandom_range(0, 99) >= idle_pct) begin
				cur = cmds_pending.pop_front();
				op        <= cur.op;
				node      <= cur.target;
				value     <= cur.word;
				link_next <= cur.next_idx;
				link_prev <= cur.prev_idx;
				start     <= 1'b1;
				issued++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check results and predict accepted transactions at the rising edge
	always @(posedge clk) begin
		list_reply_t want;
		if (!arst_n) begin
			taken <= 1'b0;
		end else begin
			taken <= start && !busy;
			// results are checked before this edge's transaction is predicted
			if (done) begin
				if (replies_due.size() == 0) begin
					$error("result with nothing expected: kind %0d, result_value %0h",
						kind, result_value);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					if (kind !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, kind);
						mismatches++;
					end
					if (result_value !== want.val) begin
						$error("result_value: expected %0h, actual %0h", want.val, result_value);
						mismatches++;
					end
					if (refused !== want.refused) begin
						$error("refused: expected %0d, actual %0d", want.refused, refused);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				accepted++;
				if (step_list(CHECK, cur, want)) begin
					replies_due.push_back(want);
				end
			end
		end
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
